>>> sv/ssfs_pkg.sv
package ssfs_pkg;

	localparam int unsigned LEN_W = 5;
	localparam int unsigned POS_W = 17;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned NB_COUNT = 16;
	localparam int unsigned NB_IDX_W = 4;

	localparam int unsigned NEEDLE_MAX_DEF = 16;
	localparam longint unsigned HAY_MAX_DEF = 65535;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEEDLE_LOW = 2'd0,
		REG_NEEDLE_HIGH = 2'd1,
		REG_NEEDLE_LENGTH = 2'd2,
		REG_START_POSITION = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] hay_byte;
		logic has_byte;
		logic last;
	} in_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic too_long;
	} out_t;

	typedef struct packed {
		logic [NB_COUNT-1:0][7:0] needle;
		logic [LEN_W-1:0] eff_len;
		logic [POS_W-1:0] eff_start;
	} cfg_t;

endpackage

>>> sv/ssfs_cfg.sv
module ssfs_cfg #(
	parameter int unsigned NEEDLE_MAX = ssfs_pkg::NEEDLE_MAX_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic we,
	input logic [ssfs_pkg::CFG_IDX_W-1:0] index,
	input logic [ssfs_pkg::CFG_DATA_W-1:0] data,
	output ssfs_pkg::cfg_t cfg
);
	import ssfs_pkg::*;

	logic [63:0] needle_low_q;
	logic [63:0] needle_high_q;
	logic [LEN_W-1:0] needle_length_q;
	logic [POS_W-1:0] start_position_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q <= '0;
			needle_high_q <= '0;
			needle_length_q <= '0;
			start_position_q <= POS_W'(1);
		end else if (we) begin
			case (reg_idx_t'(index))
				REG_NEEDLE_LOW: needle_low_q <= data[63:0];
				REG_NEEDLE_HIGH: needle_high_q <= data[63:0];
				REG_NEEDLE_LENGTH: needle_length_q <= data[LEN_W-1:0];
				REG_START_POSITION: start_position_q <= data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.needle = {needle_high_q, needle_low_q};
		cfg.eff_len = (needle_length_q > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
			: needle_length_q;
		cfg.eff_start = (start_position_q <= POS_W'(1)) ? POS_W'(1) : start_position_q;
	end

endmodule

>>> sv/ssfs_scan.sv
module ssfs_scan #(
	parameter int unsigned NEEDLE_MAX = ssfs_pkg::NEEDLE_MAX_DEF,
	parameter longint unsigned HAY_MAX = ssfs_pkg::HAY_MAX_DEF
) (
	input logic clk,
	input logic arst_n,
	input ssfs_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input ssfs_pkg::in_t in_data,
	input logic res_free,
	output logic res_push,
	output ssfs_pkg::out_t res_data
);
	import ssfs_pkg::*;

	localparam int unsigned CNT_W = $clog2(HAY_MAX + 1);
	localparam int unsigned MW = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(HAY_MAX);

	logic valid_s1;
	in_t item_s1;
	logic adv;

	logic [NEEDLE_MAX-1:0][7:0] win_q;
	logic [CNT_W-1:0] cnt_q;
	logic found_q;
	logic [CNT_W-1:0] index_q;
	logic ovf_q;

	logic [NEEDLE_MAX-1:0][7:0] win_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic found_nx;
	logic [CNT_W-1:0] index_nx;
	logic ovf_nx;
	logic [NEEDLE_MAX-1:0] lane_ok;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] begin_pos;
	logic [MW-1:0] p0;
	logic [MW-1:0] empty_pos;
	logic [MW-1:0] index_ext;

	assign adv = valid_s1 && (!item_s1.last || res_free);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		win_nx[0] = item_s1.hay_byte;
		for (int k = 1; k < NEEDLE_MAX; k++) begin
			win_nx[k] = win_q[k-1];
		end
	end

	for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_lane
		logic [LEN_W-1:0] nidx;
		assign nidx = cfg.eff_len - LEN_W'(i + 1);
		assign lane_ok[i] = (LEN_W'(i) >= cfg.eff_len)
			|| (win_nx[i] == cfg.needle[nidx[NB_IDX_W-1:0]]);
	end

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign begin_pos = cnt_inc - CNT_W'(cfg.eff_len) + CNT_W'(1);

	always_comb begin
		cnt_nx = cnt_q;
		found_nx = found_q;
		index_nx = index_q;
		ovf_nx = ovf_q;
		if (item_s1.has_byte) begin
			if (cnt_q >= CNT_LIMIT) begin
				ovf_nx = 1'b1;
			end else begin
				cnt_nx = cnt_inc;
				if (!found_q && cfg.eff_len != '0 && cnt_inc >= CNT_W'(cfg.eff_len)
					&& MW'(begin_pos) >= MW'(cfg.eff_start) && (&lane_ok)) begin
					found_nx = 1'b1;
					index_nx = begin_pos;
				end
			end
		end
	end

	always_comb begin
		p0 = MW'(cfg.eff_start - POS_W'(1));
		if (p0 > MW'(cnt_nx)) begin
			p0 = MW'(cnt_nx);
		end
		empty_pos = p0 + MW'(1);
		index_ext = found_nx ? MW'(index_nx) : '0;
		res_data.position = (cfg.eff_len == '0) ? empty_pos[POS_W-1:0]
			: index_ext[POS_W-1:0];
		res_data.too_long = ovf_nx;
	end

	assign res_push = adv && item_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			cnt_q <= '0;
			found_q <= 1'b0;
			index_q <= '0;
			ovf_q <= 1'b0;
		end else if (adv) begin
			if (item_s1.last) begin
				win_q <= '0;
				cnt_q <= '0;
				found_q <= 1'b0;
				index_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (item_s1.has_byte && cnt_q < CNT_LIMIT) begin
					win_q <= win_nx;
				end
				cnt_q <= cnt_nx;
				found_q <= found_nx;
				index_q <= index_nx;
				ovf_q <= ovf_nx;
			end
		end
	end

`ifndef SYNTH
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LIMIT)
		else $error("byte count above limit");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == CNT_LIMIT))
		else $error("overflow flag without saturated count");

	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (index_q != '0 && index_q <= cnt_q))
		else $error("match index outside seen bytes");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled transaction lost");
`endif

endmodule

>>> sv/ssfs_obuf.sv
module ssfs_obuf (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ssfs_pkg::out_t push_data,
	output logic free,
	output logic out_valid,
	input logic out_ready,
	output ssfs_pkg::out_t out_data
);
	import ssfs_pkg::*;

	logic valid_q;
	out_t data_q;

	assign free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule

>>> sv/substring_search_from_start_core.sv
// Streaming substring search with a start position.
// Configure the needle bytes, the needle length and the one-based start position
// through the write port while no haystack is in flight. Then send the haystack
// one byte per input transaction; the transaction with last set closes it, and a
// transaction with has_byte low and last set marks an empty haystack.
// Each closed haystack yields one output transaction: the one-based position of
// the first match at or after the start, zero for none, and the too_long flag.
// The input side takes one transaction per cycle while in_ready is high. An item
// waits in the input register while the whole needle is compared against the byte
// window in parallel; when its last transaction leaves the input register, the
// result is written to the output register and offered on the output.
// The output register holds a result until it is taken; while it is held, a
// following last transaction waits in the input register and in_ready drops.
// Reset clears the window, the counters and the output valid flag, sets the
// needle to empty and the start position to one.
module substring_search_from_start_core #(
	parameter int unsigned NEEDLE_MAX = ssfs_pkg::NEEDLE_MAX_DEF,
	parameter longint unsigned HAY_MAX = ssfs_pkg::HAY_MAX_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ssfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ssfs_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input ssfs_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ssfs_pkg::out_t out_data
);
	import ssfs_pkg::*;

	cfg_t cfg;
	logic res_free;
	logic res_push;
	out_t res_data;

	ssfs_cfg #(
		.NEEDLE_MAX(NEEDLE_MAX)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.we(cfg_we),
		.index(cfg_index),
		.data(cfg_data),
		.cfg(cfg)
	);

	ssfs_scan #(
		.NEEDLE_MAX(NEEDLE_MAX),
		.HAY_MAX(HAY_MAX)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.res_free(res_free),
		.res_push(res_push),
		.res_data(res_data)
	);

	ssfs_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.push_data(res_data),
		.free(res_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
